// ----- rtl/aodvrt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package aodvrt_pkg;

  typedef enum logic [1:0] {
    FN_REQ  = 2'd0,
    FN_REP  = 2'd1,
    FN_DATA = 2'd2,
    FN_TICK = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ACT_BCAST = 2'd0,
    ACT_REPLY = 2'd1,
    ACT_DATA  = 2'd2
  } act_t;

  localparam logic CFG_OWN  = 1'b0;
  localparam logic CFG_LIFE = 1'b1;

  localparam logic [6:0] ROUTE_MAX_AGE = 7'd120;
  localparam logic [4:0] REQUEST_WRAP  = 5'd25;
  localparam logic [4:0] RESULT_LIMIT  = 5'd16;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] next_hop;
    logic [4:0] rid;
    logic [7:0] src;
    logic [7:0] tgt;
    logic [7:0] hops;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_FINISH,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic latch;
    logic decode;
    logic scan_step;
    logic finish;
    logic emit;
  } cmd_t;

  typedef struct packed {
    func_t func;
    logic  own_hit;
    logic  in_range;
    logic  shorter;
    logic  route_v;
    logic  scan_last;
    logic  scan_stall;
    logic  pend_v;
    logic  out_free;
  } sts_t;

endpackage
`default_nettype wire

// ----- rtl/aodvrt_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface aodvrt_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [4:0] request_id;
  logic [7:0] source_address;
  logic [7:0] target_address;
  logic [7:0] hop_count;
  logic [7:0] from_address;

  modport source (output valid, func, request_id, source_address, target_address,
                  hop_count, from_address, input ready);
  modport sink   (input valid, func, request_id, source_address, target_address,
                  hop_count, from_address, output ready);
endinterface
`default_nettype wire

// ----- rtl/aodvrt_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface aodvrt_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] next_hop;
  logic [4:0] out_request_id;
  logic [7:0] out_source;
  logic [7:0] out_target;
  logic [7:0] out_hops;
  logic       last;

  modport source (output valid, action, next_hop, out_request_id, out_source,
                  out_target, out_hops, last, input ready);
  modport sink   (input valid, action, next_hop, out_request_id, out_source,
                  out_target, out_hops, last, output ready);
endinterface
`default_nettype wire

// ----- rtl/aodv_route_discovery_tables_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Route and discovery tables of an on-demand routing node.
// in_ch: one event per beat (request arrival, reply arrival, data lookup, tick),
//   accepted when valid and ready are high; ready is high only while idle.
// out_ch: zero or more result beats per event; last marks the final one.
// cfg_*: write own_address (index 0) or discovery_lifetime (index 1) while idle.
// Flow: a tick or an ignored event is accepted, decoded and done; a request for
//   this node or a data hit goes from decode straight to the result stage.
//   Events that touch the discovery table walk it one entry per cycle while
//   no forwarding walk pauses, then finish and emit a last result if one is
//   pending, the walk being the limiting loop. Route aging is done for all
//   routes at once, during decode.
// A registered output stage holds each result; while the receiver stalls,
//   a forwarding walk pauses until the pending result can move on.
// Reset (synchronous, rst_n low): routes and discovery entries invalid,
//   request counter 1, own_address 1, discovery_lifetime 10.
module aodv_route_discovery_tables_top #(
  parameter int NODES        = 16,
  parameter int DISC_ENTRIES = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [7:0] cfg_wdata,
  aodvrt_in_if.sink       in_ch,
  aodvrt_out_if.source    out_ch
);
  import aodvrt_pkg::*;

  cmd_t cmd;
  sts_t sts;
  res_t res;

  aodvrt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  aodvrt_dp #(
    .NODES        (NODES),
    .DISC_ENTRIES (DISC_ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_func   (in_ch.func),
    .in_rid    (in_ch.request_id),
    .in_src    (in_ch.source_address),
    .in_tgt    (in_ch.target_address),
    .in_hops   (in_ch.hop_count),
    .in_from   (in_ch.from_address),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_res   (res),
    .out_last  (out_ch.last)
  );

  assign out_ch.action         = res.action;
  assign out_ch.next_hop       = res.next_hop;
  assign out_ch.out_request_id = res.rid;
  assign out_ch.out_source     = res.src;
  assign out_ch.out_target     = res.tgt;
  assign out_ch.out_hops       = res.hops;
endmodule
`default_nettype wire

// ----- rtl/aodvrt_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module aodvrt_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire aodvrt_pkg::sts_t sts,
  output aodvrt_pkg::cmd_t   cmd
);
  import aodvrt_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd.decode = 1'b1;
        unique case (sts.func)
          FN_REQ:  state_nxt = sts.own_hit ? ST_EMIT : ST_SCAN;
          FN_REP:  state_nxt = (sts.in_range && sts.shorter) ? ST_SCAN : ST_IDLE;
          FN_DATA: begin
            if (!sts.in_range) state_nxt = ST_IDLE;
            else if (sts.route_v) state_nxt = ST_EMIT;
            else state_nxt = ST_SCAN;
          end
          FN_TICK: state_nxt = ST_IDLE;
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_SCAN: begin
        if (!sts.scan_stall) begin
          cmd.scan_step = 1'b1;
          if (sts.scan_last) state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = ST_EMIT;
      end
      ST_EMIT: begin
        if (!sts.pend_v) begin
          state_nxt = ST_IDLE;
        end else if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ----- rtl/aodvrt_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
module aodvrt_dp #(
  parameter int NODES        = 16,
  parameter int DISC_ENTRIES = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [7:0] cfg_wdata,
  input  wire logic [1:0] in_func,
  input  wire logic [4:0] in_rid,
  input  wire logic [7:0] in_src,
  input  wire logic [7:0] in_tgt,
  input  wire logic [7:0] in_hops,
  input  wire logic [7:0] in_from,
  input  wire aodvrt_pkg::cmd_t cmd,
  output aodvrt_pkg::sts_t sts,
  input  wire logic       out_ready,
  output logic            out_valid,
  output aodvrt_pkg::res_t out_res,
  output logic            out_last
);
  import aodvrt_pkg::*;

  localparam int NW = $clog2(NODES);
  localparam int DW = (DISC_ENTRIES > 1) ? $clog2(DISC_ENTRIES) : 1;

  logic [7:0] own_r, life_r;
  func_t      func_r;
  logic [4:0] rid_r;
  logic [7:0] src_r, tgt_r, hops_r, from_r;
  logic [4:0] ctr_r;

  logic       rv_r [NODES];
  logic [7:0] rn_r [NODES];
  logic [7:0] rh_r [NODES];
  logic [6:0] ra_r [NODES];

  logic       dv_r    [DISC_ENTRIES];
  logic [4:0] dreq_r  [DISC_ENTRIES];
  logic [7:0] dsrc_r  [DISC_ENTRIES];
  logic [7:0] dtgt_r  [DISC_ENTRIES];
  logic [7:0] dfwd_r  [DISC_ENTRIES];
  logic [7:0] dlife_r [DISC_ENTRIES];

  logic [DW-1:0] idx_r, free_idx_r, clr_idx_r;
  logic          dup_r, free_f_r, clr_f_r;
  logic [4:0]    cnt_r;
  logic          pend_v_r;
  res_t          pend_r;
  logic          out_v_r, out_last_r;
  res_t          out_r;

  logic [NW-1:0] d;
  logic          in_range, own_hit, route_v, shorter;
  logic          e_v, rep_hit, dup_hit, fwd_hit, out_free;
  logic [7:0]    h_inc;
  logic [7:0]    eff_hops;

  assign in_range = (tgt_r != 8'd0) && (tgt_r <= 8'(NODES));
  assign d        = NW'(tgt_r - 8'd1);
  assign own_hit  = (tgt_r == own_r);
  assign route_v  = rv_r[d];
  assign eff_hops = rv_r[d] ? rh_r[d] : 8'd255;
  assign shorter  = hops_r < eff_hops;
  assign h_inc    = (hops_r < 8'd255) ? hops_r + 8'd1 : 8'd255;

  assign e_v      = dv_r[idx_r];
  assign rep_hit  = e_v && (dreq_r[idx_r] == rid_r) && (dtgt_r[idx_r] == tgt_r);
  assign dup_hit  = rep_hit && (dsrc_r[idx_r] == src_r);
  assign fwd_hit  = (func_r == FN_REP) && (src_r != own_r) && rep_hit
                    && (cnt_r < RESULT_LIMIT);
  assign out_free = !out_v_r || out_ready;

  assign sts.func       = func_r;
  assign sts.own_hit    = own_hit;
  assign sts.in_range   = in_range;
  assign sts.shorter    = shorter;
  assign sts.route_v    = route_v;
  assign sts.scan_last  = (idx_r == DW'(DISC_ENTRIES - 1));
  assign sts.scan_stall = fwd_hit && pend_v_r && !out_free;
  assign sts.pend_v     = pend_v_r;
  assign sts.out_free   = out_free;

  assign out_valid = out_v_r;
  assign out_res   = out_r;
  assign out_last  = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_r    <= 8'd1;
      life_r   <= 8'd10;
      ctr_r    <= 5'd1;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
      for (int i = 0; i < NODES; i++) rv_r[i] <= 1'b0;
      for (int i = 0; i < DISC_ENTRIES; i++) dv_r[i] <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_OWN) own_r <= cfg_wdata;
        else life_r <= cfg_wdata;
      end
      if (out_ready) out_v_r <= 1'b0;

      if (cmd.latch) begin
        func_r <= func_t'(in_func);
        rid_r  <= in_rid;
        src_r  <= in_src;
        tgt_r  <= in_tgt;
        hops_r <= in_hops;
        from_r <= in_from;
      end

      if (cmd.decode) begin
        idx_r    <= '0;
        dup_r    <= 1'b0;
        free_f_r <= 1'b0;
        clr_f_r  <= 1'b0;
        cnt_r    <= '0;
        pend_v_r <= 1'b0;
        unique case (func_r)
          FN_REQ: begin
            if (own_hit) begin
              pend_v_r <= 1'b1;
              pend_r   <= '{ACT_REPLY, from_r, rid_r, src_r, tgt_r, 8'd0};
            end
          end
          FN_REP: begin
            if (in_range && shorter) begin
              rv_r[d] <= 1'b1;
              rn_r[d] <= from_r;
              rh_r[d] <= hops_r;
              ra_r[d] <= 7'd1;
            end
          end
          FN_DATA: begin
            if (in_range && route_v) begin
              pend_v_r <= 1'b1;
              pend_r   <= '{ACT_DATA, rn_r[d], 5'd0, own_r, tgt_r, 8'd0};
            end
          end
          FN_TICK: begin
            for (int i = 0; i < NODES; i++) begin
              if (rv_r[i] && ra_r[i] < ROUTE_MAX_AGE) begin
                ra_r[i] <= ra_r[i] + 7'd1;
                if (ra_r[i] + 7'd1 == ROUTE_MAX_AGE) rv_r[i] <= 1'b0;
              end
            end
            for (int i = 0; i < DISC_ENTRIES; i++) begin
              if (dv_r[i]) begin
                if (dlife_r[i] <= 8'd1) dv_r[i] <= 1'b0;
                else dlife_r[i] <= dlife_r[i] - 8'd1;
              end
            end
          end
          default: ;
        endcase
      end

      if (cmd.scan_step) begin
        idx_r <= idx_r + DW'(1);
        if (dup_hit) dup_r <= 1'b1;
        if (!e_v && !free_f_r) begin
          free_f_r   <= 1'b1;
          free_idx_r <= idx_r;
        end
        if (rep_hit && !clr_f_r) begin
          clr_f_r   <= 1'b1;
          clr_idx_r <= idx_r;
        end
        if (fwd_hit) begin
          cnt_r    <= cnt_r + 5'd1;
          pend_v_r <= 1'b1;
          pend_r   <= '{ACT_REPLY, dfwd_r[idx_r], rid_r, src_r, tgt_r, h_inc};
          if (pend_v_r) begin
            out_v_r    <= 1'b1;
            out_r      <= pend_r;
            out_last_r <= 1'b0;
          end
        end
      end

      if (cmd.finish) begin
        unique case (func_r)
          FN_REQ: begin
            if (!dup_r) begin
              if (free_f_r) begin
                dv_r[free_idx_r]    <= 1'b1;
                dreq_r[free_idx_r]  <= rid_r;
                dsrc_r[free_idx_r]  <= src_r;
                dtgt_r[free_idx_r]  <= tgt_r;
                dfwd_r[free_idx_r]  <= from_r;
                dlife_r[free_idx_r] <= life_r;
              end
              pend_v_r <= 1'b1;
              pend_r   <= '{ACT_BCAST, 8'd0, rid_r, src_r, tgt_r, 8'd0};
            end
          end
          FN_REP: begin
            if (clr_f_r) dv_r[clr_idx_r] <= 1'b0;
          end
          FN_DATA: begin
            if (free_f_r) begin
              dv_r[free_idx_r]    <= 1'b1;
              dreq_r[free_idx_r]  <= ctr_r;
              dsrc_r[free_idx_r]  <= own_r;
              dtgt_r[free_idx_r]  <= tgt_r;
              dfwd_r[free_idx_r]  <= own_r;
              dlife_r[free_idx_r] <= life_r;
            end
            pend_v_r <= 1'b1;
            pend_r   <= '{ACT_BCAST, 8'd0, ctr_r, own_r, tgt_r, 8'd0};
            ctr_r    <= (ctr_r >= 5'd1 && ctr_r < REQUEST_WRAP) ? ctr_r + 5'd1 : 5'd1;
          end
          default: ;
        endcase
      end

      if (cmd.emit) begin
        out_v_r    <= 1'b1;
        out_r      <= pend_r;
        out_last_r <= 1'b1;
        pend_v_r   <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire
